// ===== hdl/sym3inv_pkg.sv =====
// ----------------------------------------------------------------------------
// sym3inv_pkg
// Shared widths, types and latency of the symmetric 3x3 inverse pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package sym3inv_pkg;

  localparam int DW   = 32;              // data width
  localparam int FB   = 16;              // fraction bits
  localparam int PW   = 2 * DW;          // product width
  localparam int CW   = PW + 1;          // cofactor width
  localparam int LOW  = CW - DW;         // low split of a cofactor
  localparam int DETW = DW + CW + 2;     // determinant width
  localparam int NUMW = CW + 2 * FB;     // numerator magnitude width
  localparam int QB   = DW + 1;          // quotient bits kept
  localparam int HIW  = NUMW - QB;       // numerator bits above the quotient
  localparam int RW   = DETW + 1;        // divider remainder width
  localparam int NV   = QB + 8;          // length of the valid pipeline

  typedef logic signed [DW-1:0] data_t;
  typedef logic signed [CW-1:0] cof_t;
  typedef logic [DETW-1:0]      den_t;
  typedef logic [NUMW-1:0]      num_t;

endpackage

`default_nettype wire

// ===== hdl/sym3inv_div.sv =====
// ----------------------------------------------------------------------------
// sym3inv_div
// Pipelined restoring divider, one quotient bit per stage, with saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module sym3inv_div (
  input  wire logic               clk,
  input  wire sym3inv_pkg::num_t  num,
  input  wire sym3inv_pkg::den_t  den,
  input  wire logic               neg,
  input  wire logic               big,
  output sym3inv_pkg::data_t      quo,
  output logic                    ovf
);
  import sym3inv_pkg::*;

  localparam logic [QB-1:0] HALF = QB'(1) << (DW - 1);

  logic [RW-1:0]   rem_r  [0:QB-1];
  logic [QB-1:0]   nlo_r  [0:QB-1];
  logic [DETW-1:0] den_r  [0:QB-1];
  logic [QB-1:0]   q_r    [0:QB-1];
  logic            neg_r  [0:QB-1];
  logic            big_r  [0:QB-1];
  data_t           quo_r;
  logic            ovf_r;

  genvar k;
  generate
    for (k = 0; k < QB; k++) begin : g_stage
      logic [RW-1:0]   rem_in;
      logic [QB-1:0]   nlo_in;
      logic [DETW-1:0] den_in;
      logic [QB-1:0]   q_in;
      logic            neg_in;
      logic            big_in;
      logic [RW-1:0]   rem_sh;
      logic            ge;
      if (k == 0) begin : g_first
        assign rem_in = RW'(num[NUMW-1:QB]);
        assign nlo_in = num[QB-1:0];
        assign den_in = den;
        assign q_in   = '0;
        assign neg_in = neg;
        assign big_in = big;
      end else begin : g_next
        assign rem_in = rem_r[k-1];
        assign nlo_in = nlo_r[k-1];
        assign den_in = den_r[k-1];
        assign q_in   = q_r[k-1];
        assign neg_in = neg_r[k-1];
        assign big_in = big_r[k-1];
      end
      assign rem_sh = {rem_in[RW-2:0], nlo_in[QB-1-k]};
      assign ge     = rem_sh >= {1'b0, den_in};
      always_ff @(posedge clk) begin
        rem_r[k] <= ge ? (rem_sh - {1'b0, den_in}) : rem_sh;
        nlo_r[k] <= nlo_in;
        den_r[k] <= den_in;
        q_r[k]   <= {q_in[QB-2:0], ge};
        neg_r[k] <= neg_in;
        big_r[k] <= big_in;
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (neg_r[QB-1]) begin
      if (big_r[QB-1] || (q_r[QB-1] > HALF)) begin
        quo_r <= {1'b1, {(DW-1){1'b0}}};
        ovf_r <= 1'b1;
      end else begin
        quo_r <= -$signed(q_r[QB-1][DW-1:0]);
        ovf_r <= 1'b0;
      end
    end else begin
      if (big_r[QB-1] || (q_r[QB-1] > (HALF - QB'(1)))) begin
        quo_r <= {1'b0, {(DW-1){1'b1}}};
        ovf_r <= 1'b1;
      end else begin
        quo_r <= $signed(q_r[QB-1][DW-1:0]);
        ovf_r <= 1'b0;
      end
    end
  end

  assign quo = quo_r;
  assign ovf = ovf_r;

endmodule

`default_nettype wire

// ===== hdl/symmetric_3x3_inverse.sv =====
// ----------------------------------------------------------------------------
// symmetric_3x3_inverse
// Inverse of a symmetric 3x3 fixed-point matrix, fully pipelined.
// ----------------------------------------------------------------------------
// Input: raise start with the six upper-triangle entries on in_m*; the item
// is taken at that edge. busy is always low, so one item can enter per cycle.
// Output: out_valid is high for one cycle with out_inv*, out_singular and
// out_overflow; the result must be taken in that cycle.
// Pipeline: products, cofactors, determinant partial products, terms,
// determinant and divider operands, then 33 divider stages of one
// quotient bit each, then saturation and output registers. Throughput: one item
// per cycle, set by the one-bit-per-stage divider pipeline.
// Entries are Q15.16; each inverse entry is truncated toward zero and
// saturated, setting out_overflow. A zero determinant gives zero entries
// with out_singular.
// Reset clears the valid pipeline; items in flight are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module symmetric_3x3_inverse (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire sym3inv_pkg::data_t in_m00,
  input  wire sym3inv_pkg::data_t in_m01,
  input  wire sym3inv_pkg::data_t in_m02,
  input  wire sym3inv_pkg::data_t in_m11,
  input  wire sym3inv_pkg::data_t in_m12,
  input  wire sym3inv_pkg::data_t in_m22,
  output logic                    out_valid,
  output sym3inv_pkg::data_t      out_inv00,
  output sym3inv_pkg::data_t      out_inv01,
  output sym3inv_pkg::data_t      out_inv02,
  output sym3inv_pkg::data_t      out_inv11,
  output sym3inv_pkg::data_t      out_inv12,
  output sym3inv_pkg::data_t      out_inv22,
  output logic                    out_singular,
  output logic                    out_overflow
);
  import sym3inv_pkg::*;

  typedef logic signed [PW-1:0]    prod_t;
  typedef logic signed [DETW-1:0]  det_t;
  typedef logic signed [DW+LOW:0]  pl_t;

  logic [NV-1:0] vld_r, vld_nxt;
  logic [QB+2:0] sing_r;

  // stage 1: products
  prod_t p_df_r, p_ee_r, p_ce_r, p_bf_r, p_be_r, p_cd_r;
  prod_t p_af_r, p_cc_r, p_bc_r, p_ae_r, p_ad_r, p_bb_r;
  data_t a1_r, b1_r, c1_r;
  // stage 2: cofactors
  cof_t  cof2_r [0:5];
  data_t a2_r, b2_r, c2_r;
  // stage 3: partial products of the determinant
  pl_t   pl3_r  [0:2];
  prod_t ph3_r  [0:2];
  cof_t  cof3_r [0:5];
  // stage 4: terms
  det_t  t4_r   [0:2];
  cof_t  cof4_r [0:5];
  // stage 5: determinant
  det_t  det5_r;
  cof_t  cof5_r [0:5];
  // stage 6: divider operands
  num_t  num6_r [0:5];
  den_t  den6_r;
  logic  neg6_r [0:5];
  logic  big6_r [0:5];

  data_t quo    [0:5];
  logic  ovf    [0:5];
  data_t inv_r  [0:5];
  logic  ovf_r;

  assign busy    = 1'b0;
  assign vld_nxt = {vld_r[NV-2:0], start};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_df_r <= in_m11 * in_m22;
    p_ee_r <= in_m12 * in_m12;
    p_ce_r <= in_m02 * in_m12;
    p_bf_r <= in_m01 * in_m22;
    p_be_r <= in_m01 * in_m12;
    p_cd_r <= in_m02 * in_m11;
    p_af_r <= in_m00 * in_m22;
    p_cc_r <= in_m02 * in_m02;
    p_bc_r <= in_m01 * in_m02;
    p_ae_r <= in_m00 * in_m12;
    p_ad_r <= in_m00 * in_m11;
    p_bb_r <= in_m01 * in_m01;
    a1_r   <= in_m00;
    b1_r   <= in_m01;
    c1_r   <= in_m02;
  end

  always_ff @(posedge clk) begin
    cof2_r[0] <= CW'(p_df_r) - CW'(p_ee_r);
    cof2_r[1] <= CW'(p_ce_r) - CW'(p_bf_r);
    cof2_r[2] <= CW'(p_be_r) - CW'(p_cd_r);
    cof2_r[3] <= CW'(p_af_r) - CW'(p_cc_r);
    cof2_r[4] <= CW'(p_bc_r) - CW'(p_ae_r);
    cof2_r[5] <= CW'(p_ad_r) - CW'(p_bb_r);
    a2_r <= a1_r;
    b2_r <= b1_r;
    c2_r <= c1_r;
  end

  always_ff @(posedge clk) begin
    pl3_r[0] <= a2_r * $signed({1'b0, cof2_r[0][LOW-1:0]});
    pl3_r[1] <= b2_r * $signed({1'b0, cof2_r[1][LOW-1:0]});
    pl3_r[2] <= c2_r * $signed({1'b0, cof2_r[2][LOW-1:0]});
    ph3_r[0] <= a2_r * $signed(cof2_r[0][CW-1:LOW]);
    ph3_r[1] <= b2_r * $signed(cof2_r[1][CW-1:LOW]);
    ph3_r[2] <= c2_r * $signed(cof2_r[2][CW-1:LOW]);
    cof3_r   <= cof2_r;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      t4_r[i] <= (DETW'(ph3_r[i]) <<< LOW) + DETW'(pl3_r[i]);
    end
    cof4_r <= cof3_r;
  end

  always_ff @(posedge clk) begin
    det5_r <= t4_r[0] + t4_r[1] + t4_r[2];
    cof5_r <= cof4_r;
  end

  // magnitudes, signs and the quotient-too-wide check
  always_ff @(posedge clk) begin
    logic [DETW-1:0] dmag;
    logic [CW-1:0]   cmag;
    num_t            nmag;
    dmag   = det5_r[DETW-1] ? DETW'(-det5_r) : DETW'(det5_r);
    den6_r <= dmag;
    for (int i = 0; i < 6; i++) begin
      cmag      = cof5_r[i][CW-1] ? CW'(-cof5_r[i]) : CW'(cof5_r[i]);
      nmag      = {cmag, {(2*FB){1'b0}}};
      num6_r[i] <= nmag;
      neg6_r[i] <= cof5_r[i][CW-1] ^ det5_r[DETW-1];
      big6_r[i] <= RW'(nmag[NUMW-1:QB]) >= RW'(dmag);
    end
  end

  always_ff @(posedge clk) begin
    sing_r <= {sing_r[QB+1:0], (det5_r == '0)};
  end

  genvar g;
  generate
    for (g = 0; g < 6; g++) begin : g_div
      sym3inv_div u_div (
        .clk (clk),
        .num (num6_r[g]),
        .den (den6_r),
        .neg (neg6_r[g]),
        .big (big6_r[g]),
        .quo (quo[g]),
        .ovf (ovf[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    for (int i = 0; i < 6; i++) begin
      inv_r[i] <= sing_r[QB+1] ? '0 : quo[i];
    end
    ovf_r <= !sing_r[QB+1] && (ovf[0] || ovf[1] || ovf[2] || ovf[3] || ovf[4] || ovf[5]);
  end

  assign out_valid    = vld_r[NV-1];
  assign out_inv00    = inv_r[0];
  assign out_inv01    = inv_r[1];
  assign out_inv02    = inv_r[2];
  assign out_inv11    = inv_r[3];
  assign out_inv12    = inv_r[4];
  assign out_inv22    = inv_r[5];
  assign out_singular = sing_r[QB+2];
  assign out_overflow = ovf_r;

endmodule

`default_nettype wire

// ===== hdl/sym3inv_chk.sv =====
// ----------------------------------------------------------------------------
// sym3inv_chk
// Port-level checks of the symmetric 3x3 inverse.
// ----------------------------------------------------------------------------
`default_nettype none

module sym3inv_chk (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               out_valid,
  input wire sym3inv_pkg::data_t out_inv00,
  input wire sym3inv_pkg::data_t out_inv11,
  input wire sym3inv_pkg::data_t out_inv22,
  input wire logic               out_singular,
  input wire logic               out_overflow
);
  import sym3inv_pkg::*;

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, NV))
    else $error("result without an item");

  a_sing_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_singular |-> !out_overflow)
    else $error("singular with overflow");

  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_singular |-> out_inv00 == '0 && out_inv11 == '0 && out_inv22 == '0)
    else $error("singular result not zero");

endmodule

bind symmetric_3x3_inverse sym3inv_chk u_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .out_valid    (out_valid),
  .out_inv00    (out_inv00),
  .out_inv11    (out_inv11),
  .out_inv22    (out_inv22),
  .out_singular (out_singular),
  .out_overflow (out_overflow)
);

`default_nettype wire

// ===== sim/tb_symmetric_3x3_inverse.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_symmetric_3x3_inverse
// Drives random and corner-case symmetric matrices into the inverse pipeline
// and checks every result against an exact wide-integer predictor.
// ----------------------------------------------------------------------------

class inv_scoreboard;
  typedef struct {
    logic signed [31:0] inv [6];
    logic               sing;
    logic               ovf;
  } inv_res_t;

  inv_res_t pending[$];
  int       errors;

  function automatic logic signed [31:0] div_entry(logic signed [255:0] cof,
      logic signed [255:0] det, ref logic ovf);
    logic signed [255:0] num;
    logic signed [255:0] q;
    num = cof <<< 32;
    q = num / det;
    if (q > 256'sd2147483647) begin
      ovf = 1'b1;
      return 32'sh7fffffff;
    end
    if (q < -256'sd2147483648) begin
      ovf = 1'b1;
      return 32'sh80000000;
    end
    return q[31:0];
  endfunction

  function void note_matrix(logic signed [31:0] m [6]);
    logic signed [255:0] a, b, c, d, e, f, det;
    logic signed [255:0] cf [6];
    inv_res_t r;
    a = m[0]; b = m[1]; c = m[2]; d = m[3]; e = m[4]; f = m[5];
    cf[0] = d * f - e * e;
    cf[1] = c * e - b * f;
    cf[2] = b * e - c * d;
    cf[3] = a * f - c * c;
    cf[4] = b * c - a * e;
    cf[5] = a * d - b * b;
    det = a * cf[0] + b * cf[1] + c * cf[2];
    r.ovf = 1'b0;
    r.sing = (det == 0);
    for (int k = 0; k < 6; k++)
      r.inv[k] = r.sing ? 32'sd0 : div_entry(cf[k], det, r.ovf);
    pending.push_back(r);
  endfunction

  function void check_result(logic signed [31:0] v [6], logic s, logic o);
    inv_res_t x;
    logic bad;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result item");
      return;
    end
    x = pending.pop_front();
    bad = (s !== x.sing) || (o !== x.ovf);
    for (int k = 0; k < 6; k++)
      if (v[k] !== x.inv[k]) bad = 1'b1;
    if (bad) begin
      errors++;
      if (errors <= 10)
        $display("mismatch exp %h %h %h %h %h %h s%0b o%0b got %h %h %h %h %h %h s%0b o%0b",
                 x.inv[0], x.inv[1], x.inv[2], x.inv[3], x.inv[4], x.inv[5],
                 x.sing, x.ovf, v[0], v[1], v[2], v[3], v[4], v[5], s, o);
    end
  endfunction
endclass

module tb_symmetric_3x3_inverse;
  import sym3inv_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  data_t in_m00 = '0, in_m01 = '0, in_m02 = '0, in_m11 = '0, in_m12 = '0, in_m22 = '0;
  logic out_valid;
  data_t out_inv00, out_inv01, out_inv02, out_inv11, out_inv12, out_inv22;
  logic out_singular, out_overflow;

  inv_scoreboard board = new();
  int idle_pct = 0;
  longint cycles = 0;

  symmetric_3x3_inverse dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    logic signed [31:0] v [6];
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("== FAIL ==");
      $finish;
    end
    if (rst_n) begin
      if (start && !busy)
        board.note_matrix('{in_m00, in_m01, in_m02, in_m11, in_m12, in_m22});
      if (out_valid) begin
        v = '{out_inv00, out_inv01, out_inv02, out_inv11, out_inv12, out_inv22};
        board.check_result(v, out_singular, out_overflow);
      end
    end
  end

  function automatic data_t rand_entry();
    case ($urandom_range(0, 9))
      0: return data_t'($urandom());
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      2: return data_t'($signed($urandom_range(0, 64)) - 32) <<< 16;
      3: return 32'sd0;
      4: return data_t'($signed($urandom_range(0, 2047)) - 1024);
      default: return data_t'($signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000);
    endcase
  endfunction

  task automatic send_matrix(data_t a, b, c, d, e, f);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_m00 <= a; in_m01 <= b; in_m02 <= c;
    in_m11 <= d; in_m12 <= e; in_m22 <= f;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random(int n);
    data_t a, b, c;
    for (int i = 0; i < n; i++) begin
      a = rand_entry();
      if ($urandom_range(0, 9) == 0) begin
        b = rand_entry(); c = rand_entry();
        send_matrix(a, b, c, a, b, c);
      end else
        send_matrix(a, rand_entry(), rand_entry(), rand_entry(), rand_entry(),
                    rand_entry());
    end
  endtask

  localparam data_t ONE = 32'sh00010000;
  localparam data_t MX = 32'sh7fffffff;
  localparam data_t MN = 32'sh80000000;

  initial begin
    int waitc;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_matrix(ONE, 0, 0, ONE, 0, 0);
    send_matrix(ONE, 0, 0, ONE, 0, ONE);
    send_matrix(0, 0, 0, 0, 0, 0);
    send_matrix(MX, MX, MX, MX, MX, MX);
    send_matrix(MN, 0, 0, MN, 0, MN);
    send_matrix(MX, 0, 0, MX, 0, MX);
    send_matrix(MN, MX, MN, MX, MN, MX);
    send_matrix(1, 0, 0, 1, 0, 1);
    send_matrix(-1, 0, 0, 1, 0, -1);
    send_matrix(ONE * 2, ONE, 0, ONE * 2, ONE, ONE * 2);
    send_matrix(-ONE * 3, ONE, ONE, ONE, 0, ONE);
    send_matrix(MX, MN, 1, -1, MX, MN);
    send_matrix(32'sh55555555, 32'shaaaaaaaa, 32'sh0f0f0f0f, 32'shf0f0f0f0, 32'sh33333333,
                32'shcccccccc);
    send_matrix(ONE, ONE, ONE, ONE, ONE, ONE);
    send_matrix(ONE / 3, 0, 0, 7, 0, -ONE);
    idle_pct = 14;
    send_random(600);
    idle_pct = 53;
    send_random(600);
    idle_pct = 0;
    send_random(600);
    start <= 1'b0;
    waitc = 0;
    while (board.pending.size() != 0 && waitc < 2000) begin
      @(posedge clk);
      waitc++;
    end
    repeat (NV + 10) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule
